FILE: rtl/cbeq_pkg.sv
// ----------------------------------------------------------------------------
// cbeq_pkg
// Shared types, codes and the section microprogram of the equalizer core.
// ----------------------------------------------------------------------------
package cbeq_pkg;

  localparam int NCOEF = 11;
  localparam logic [3:0] FETCH_LAST = 4'(NCOEF);

  typedef enum logic [1:0] {
    REQ_SAMPLE,
    REQ_COEF,
    REQ_MODE,
    REQ_COUNT
  } req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_MODE_WR,
    S_BAND,
    S_CHECK,
    S_FETCH,
    S_CALC,
    S_WB,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OPND_X,
    OPND_S0,
    OPND_S1,
    OPND_V1,
    OPND_V2,
    OPND_V3,
    OPND_OUT
  } opnd_t;

  typedef enum logic [2:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_S0,
    BASE_S1,
    BASE_NS0,
    BASE_NS1
  } base_t;

  typedef enum logic [1:0] {
    TERM_PROD,
    TERM_V1X2,
    TERM_V2X2
  } term_t;

  typedef enum logic [2:0] {
    DST_OUT,
    DST_N0,
    DST_N1,
    DST_V1,
    DST_V2
  } dst_t;

  typedef struct packed {
    logic       mul;
    logic [3:0] csel;
    opnd_t      opnd;
    logic       acc;
    base_t      base;
    term_t      term;
    logic       tneg;
    logic       wr;
    dst_t       dst;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic       clr_step;
    logic       cap;
    logic       coef_wr;
    logic       count_wr;
    logic       row_rd_cfg;
    logic       mode_wr;
    logic       row_rd_band;
    logic       band_next;
    logic       fetch_en;
    logic [3:0] fetch_idx;
    logic       cap_en;
    logic [3:0] cap_idx;
    logic       calc;
    uop_t       uop;
    logic       wb;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    req_t req;
    logic band_done;
    logic bypass;
    logic svf;
    logic out_busy;
  } sts_t;

  function automatic uop_t mk_mul(logic [3:0] c, opnd_t o);
    uop_t u;
    u = '0;
    u.mul = 1'b1;
    u.csel = c;
    u.opnd = o;
    return u;
  endfunction

  function automatic uop_t mk_acc(base_t b, term_t t, logic n);
    uop_t u;
    u = '0;
    u.acc = 1'b1;
    u.base = b;
    u.term = t;
    u.tneg = n;
    return u;
  endfunction

  function automatic uop_t mk_wr(dst_t d, logic l);
    uop_t u;
    u = '0;
    u.wr = 1'b1;
    u.dst = d;
    u.last = l;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic svf, logic [4:0] step);
    uop_t u;
    u = mk_wr(DST_N1, 1'b1);
    if (!svf) begin
      case (step)
        5'd0:    u = mk_mul(4'd0, OPND_X);
        5'd1:    u = mk_acc(BASE_S0, TERM_PROD, 1'b0);
        5'd2:    u = mk_wr(DST_OUT, 1'b0);
        5'd3:    u = mk_mul(4'd1, OPND_X);
        5'd4:    u = mk_acc(BASE_S1, TERM_PROD, 1'b0);
        5'd5:    u = mk_mul(4'd3, OPND_OUT);
        5'd6:    u = mk_acc(BASE_ACC, TERM_PROD, 1'b1);
        5'd7:    u = mk_wr(DST_N0, 1'b0);
        5'd8:    u = mk_mul(4'd2, OPND_X);
        5'd9:    u = mk_acc(BASE_ZERO, TERM_PROD, 1'b0);
        5'd10:   u = mk_mul(4'd4, OPND_OUT);
        5'd11:   u = mk_acc(BASE_ACC, TERM_PROD, 1'b1);
        5'd12:   u = mk_wr(DST_N1, 1'b1);
        default: u = mk_wr(DST_N1, 1'b1);
      endcase
    end else begin
      case (step)
        5'd0:    u = mk_mul(4'd5, OPND_S0);
        5'd1:    u = mk_acc(BASE_ZERO, TERM_PROD, 1'b0);
        5'd2:    u = mk_mul(4'd6, OPND_V3);
        5'd3:    u = mk_acc(BASE_ACC, TERM_PROD, 1'b0);
        5'd4:    u = mk_wr(DST_V1, 1'b0);
        5'd5:    u = mk_mul(4'd6, OPND_S0);
        5'd6:    u = mk_acc(BASE_S1, TERM_PROD, 1'b0);
        5'd7:    u = mk_mul(4'd7, OPND_V3);
        5'd8:    u = mk_acc(BASE_ACC, TERM_PROD, 1'b0);
        5'd9:    u = mk_wr(DST_V2, 1'b0);
        5'd10:   u = mk_acc(BASE_NS0, TERM_V1X2, 1'b0);
        5'd11:   u = mk_wr(DST_N0, 1'b0);
        5'd12:   u = mk_acc(BASE_NS1, TERM_V2X2, 1'b0);
        5'd13:   u = mk_wr(DST_N1, 1'b0);
        5'd14:   u = mk_mul(4'd8, OPND_X);
        5'd15:   u = mk_acc(BASE_ZERO, TERM_PROD, 1'b0);
        5'd16:   u = mk_mul(4'd9, OPND_V1);
        5'd17:   u = mk_acc(BASE_ACC, TERM_PROD, 1'b0);
        5'd18:   u = mk_mul(4'd10, OPND_V2);
        5'd19:   u = mk_acc(BASE_ACC, TERM_PROD, 1'b0);
        5'd20:   u = mk_wr(DST_OUT, 1'b1);
        default: u = mk_wr(DST_OUT, 1'b1);
      endcase
    end
    return u;
  endfunction

endpackage

FILE: rtl/cbeq_ctrl.sv
// ----------------------------------------------------------------------------
// cbeq_ctrl
// Sequencer: clear sweep, request dispatch, band walk, fetch and microprogram.
// ----------------------------------------------------------------------------
module cbeq_ctrl
  import cbeq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [3:0] fcnt;
  logic [4:0] step;
  uop_t       uop;

  assign uop = uop_rom(sts.svf, step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      fcnt  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      fcnt  <= (state == S_FETCH) ? fcnt + 4'd1 : '0;
      step  <= (state == S_CALC) ? step + 5'd1 : '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (sts.req)
          REQ_SAMPLE: state_next = S_BAND;
          REQ_MODE:   state_next = S_MODE_WR;
          default:    state_next = S_IDLE;
        endcase
      end
      S_MODE_WR:  state_next = S_IDLE;
      S_BAND:     state_next = sts.band_done ? S_DONE : S_CHECK;
      S_CHECK:    state_next = sts.bypass ? S_BAND : S_FETCH;
      S_FETCH:    if (fcnt == FETCH_LAST) state_next = S_CALC;
      S_CALC:     if (uop.last) state_next = S_WB;
      S_WB:       state_next = S_BAND;
      S_DONE:     if (!sts.out_busy) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    cmd.fetch_idx = fcnt;
    cmd.cap_idx = fcnt - 4'd1;
    cmd.uop = uop;
    case (state)
      S_CLEAR:    cmd.clr_step = 1'b1;
      S_IDLE:     cmd.cap = in_valid;
      S_DISPATCH: begin
        cmd.coef_wr    = (sts.req == REQ_COEF);
        cmd.count_wr   = (sts.req == REQ_COUNT);
        cmd.row_rd_cfg = (sts.req == REQ_MODE);
      end
      S_MODE_WR:  cmd.mode_wr = 1'b1;
      S_BAND:     cmd.row_rd_band = !sts.band_done;
      S_CHECK:    cmd.band_next = sts.bypass;
      S_FETCH: begin
        cmd.fetch_en = (fcnt != FETCH_LAST);
        cmd.cap_en   = (fcnt != 4'd0);
      end
      S_CALC:     cmd.calc = 1'b1;
      S_WB: begin
        cmd.wb        = 1'b1;
        cmd.band_next = 1'b1;
      end
      S_DONE:     cmd.out_load = !sts.out_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

FILE: rtl/cbeq_dp.sv
// ----------------------------------------------------------------------------
// cbeq_dp
// Datapath: coefficient and section memories, shared multiplier, accumulator,
// saturation and the output register.
// ----------------------------------------------------------------------------
module cbeq_dp
  import cbeq_pkg::*;
#(
  parameter int CHANNELS       = 16,
  parameter int BANDS          = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         req_type,
  input  logic [3:0]         channel,
  input  logic [3:0]         band,
  input  logic [3:0]         coef_select,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] sample_in,
  input  logic               bypass_flag,
  input  logic               svf_flag,
  input  logic [4:0]         band_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sample_out,
  output logic [3:0]         channel_out,
  output logic               saturated
);

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int RW      = CH_W + BAND_W;
  localparam int CLR_W   = RW + 4;
  localparam int ROWS    = 1 << RW;
  localparam int CDEPTH  = 1 << CLR_W;
  localparam int NCH     = 1 << CH_W;
  localparam int CNT_W   = $clog2(BANDS + 1);
  localparam int ACC_W   = 68 - COEF_FRAC_BITS;
  localparam int DEF_CNT = (BANDS < 10) ? BANDS : 10;
  localparam logic [31:0] COEF_ONE = 32'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  logic signed [31:0] coef_mem [CDEPTH];
  logic [65:0]        row_mem  [ROWS];

  logic [CLR_W-1:0]   clr;
  logic               clr_done;
  logic [CNT_W-1:0]   cnt [NCH];

  req_t               req;
  logic [3:0]         ch;
  logic [3:0]         bnd;
  logic [3:0]         sel;
  logic signed [31:0] coef;
  logic               byp;
  logic               svf;
  logic [4:0]         bc;
  logic [CNT_W-1:0]   ncnt;
  logic [CNT_W-1:0]   bcnt;

  logic signed [31:0] x, v1, v2, out_r, n0, n1;
  logic signed [31:0] creg [NCOEF];
  logic signed [31:0] coefq;
  logic [65:0]        rowq;
  logic signed [64:0] prod;
  logic signed [ACC_W-1:0] acc, acc_next, base, term, prod_sh;
  logic               clip;

  logic [4:0]         ch5_in, ch5;
  logic [4:0]         bnd5;
  logic               ch_ok, band_ok, ch_ok_in;
  logic [RW-1:0]      row_cfg, row_band;
  logic signed [31:0] s0, s1;
  logic signed [32:0] v3, opnd;
  logic signed [31:0] sat;
  logic               ovf;
  logic [CNT_W-1:0]   cnt_new;
  logic [63:0]        st_keep;

  assign ch5_in   = {1'b0, channel};
  assign ch5      = {1'b0, ch};
  assign bnd5     = {1'b0, bnd};
  assign ch_ok_in = ({2'b0, channel} < 6'(CHANNELS));
  assign ch_ok    = ({2'b0, ch} < 6'(CHANNELS));
  assign band_ok  = ({2'b0, bnd} < 6'(BANDS));
  assign row_cfg  = {ch5[CH_W-1:0], bnd5[BAND_W-1:0]};
  assign row_band = {ch5[CH_W-1:0], bcnt[BAND_W-1:0]};

  assign s0 = rowq[31:0];
  assign s1 = rowq[63:32];
  assign v3 = 33'(x) - 33'(s1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= '0;
      clr_done <= 1'b0;
    end else if (cmd.clr_step) begin
      clr <= clr + 1'b1;
      if (&clr) clr_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      coef_mem[clr] <= (clr[3:0] == 4'd0) ? COEF_ONE : 32'd0;
    end else if (cmd.coef_wr && ch_ok && band_ok && ({1'b0, sel} < 5'(NCOEF))) begin
      coef_mem[{row_cfg, sel}] <= coef;
    end
    if (cmd.fetch_en) begin
      coefq <= coef_mem[{row_band, cmd.fetch_idx}];
    end
  end

  assign st_keep = (svf != rowq[65]) ? 64'd0 : rowq[63:0];

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      row_mem[clr[CLR_W-1:4]] <= {2'b01, 64'd0};
    end else if (cmd.mode_wr && ch_ok && band_ok) begin
      row_mem[row_cfg] <= {svf, byp, st_keep};
    end else if (cmd.wb) begin
      row_mem[row_band] <= {rowq[65:64], n1, n0};
    end
    if (cmd.row_rd_cfg) begin
      rowq <= row_mem[row_cfg];
    end else if (cmd.row_rd_band) begin
      rowq <= row_mem[row_band];
    end
  end

  assign cnt_new = ({1'b0, bc} > 6'(BANDS)) ? CNT_W'(BANDS) : CNT_W'(bc);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) cnt[i] <= CNT_W'(DEF_CNT);
    end else if (cmd.count_wr && ch_ok) begin
      cnt[ch5[CH_W-1:0]] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req  <= req_t'(req_type);
      ch   <= channel;
      bnd  <= band;
      sel  <= coef_select;
      coef <= coef_value;
      byp  <= bypass_flag;
      svf  <= svf_flag;
      bc   <= band_count;
      ncnt <= ch_ok_in ? cnt[ch5_in[CH_W-1:0]] : '0;
      bcnt <= '0;
    end else if (cmd.band_next) begin
      bcnt <= bcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      creg[cmd.cap_idx] <= coefq;
    end
  end

  always_comb begin
    case (cmd.uop.opnd)
      OPND_X:   opnd = 33'(x);
      OPND_S0:  opnd = 33'(s0);
      OPND_S1:  opnd = 33'(s1);
      OPND_V1:  opnd = 33'(v1);
      OPND_V2:  opnd = 33'(v2);
      OPND_V3:  opnd = v3;
      OPND_OUT: opnd = 33'(out_r);
      default:  opnd = 33'(x);
    endcase
  end

  assign prod_sh = ACC_W'(prod >>> COEF_FRAC_BITS);

  always_comb begin
    case (cmd.uop.base)
      BASE_ZERO: base = '0;
      BASE_ACC:  base = acc;
      BASE_S0:   base = ACC_W'(s0);
      BASE_S1:   base = ACC_W'(s1);
      BASE_NS0:  base = -ACC_W'(s0);
      BASE_NS1:  base = -ACC_W'(s1);
      default:   base = '0;
    endcase
    case (cmd.uop.term)
      TERM_PROD: term = prod_sh;
      TERM_V1X2: term = ACC_W'(v1) <<< 1;
      TERM_V2X2: term = ACC_W'(v2) <<< 1;
      default:   term = prod_sh;
    endcase
    acc_next = cmd.uop.tneg ? base - term : base + term;
  end

  assign ovf = !((&acc[ACC_W-1:31]) || !(|acc[ACC_W-1:31]));
  assign sat = ovf ? (acc[ACC_W-1] ? SAT_MIN : SAT_MAX) : acc[31:0];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      x    <= sample_in;
      clip <= 1'b0;
    end else if (cmd.wb) begin
      x <= out_r;
    end else if (cmd.calc && cmd.uop.wr && cmd.uop.dst == DST_OUT && ovf) begin
      clip <= 1'b1;
    end
    if (cmd.calc && cmd.uop.mul) begin
      prod <= 65'(creg[cmd.uop.csel]) * 65'(opnd);
    end
    if (cmd.calc && cmd.uop.acc) begin
      acc <= acc_next;
    end
    if (cmd.calc && cmd.uop.wr) begin
      case (cmd.uop.dst)
        DST_OUT: out_r <= sat;
        DST_N0:  n0 <= sat;
        DST_N1:  n1 <= sat;
        DST_V1:  v1 <= sat;
        DST_V2:  v2 <= sat;
        default: out_r <= sat;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      sample_out  <= x;
      channel_out <= ch;
      saturated   <= clip;
    end
  end

  always_comb begin
    sts.clr_done  = clr_done;
    sts.req       = req;
    sts.band_done = (bcnt >= ncnt);
    sts.bypass    = rowq[64];
    sts.svf       = rowq[65];
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule

FILE: rtl/cascaded_biquad_svf_equalizer_core.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_svf_equalizer_core
// Per-channel cascade of biquad and state-variable equalizer sections.
// A word is taken only in idle, so each request finishes before the next.
// Sample time grows with each bypassed, biquad and state-variable band, set
// by the single shared multiplier and the one-word-per-cycle coefficient port.
// Reset runs a clearing sweep over all 2^(log2(CHANNELS)+log2(BANDS)+4)
// coefficient words with in_ready low; band counts reset to min(BANDS, 10) at once.
// ----------------------------------------------------------------------------
module cascaded_biquad_svf_equalizer_core
  import cbeq_pkg::*;
#(
  parameter int CHANNELS       = 16,
  parameter int BANDS          = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [3:0]         channel,
  input  logic [3:0]         band,
  input  logic [3:0]         coef_select,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] sample_in,
  input  logic               bypass_flag,
  input  logic               svf_flag,
  input  logic [4:0]         band_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sample_out,
  output logic [3:0]         channel_out,
  output logic               saturated
);

  cmd_t cmd;
  sts_t sts;

  cbeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbeq_dp #(
    .CHANNELS       (CHANNELS),
    .BANDS          (BANDS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .channel     (channel),
    .band        (band),
    .coef_select (coef_select),
    .coef_value  (coef_value),
    .sample_in   (sample_in),
    .bypass_flag (bypass_flag),
    .svf_flag    (svf_flag),
    .band_count  (band_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .channel_out (channel_out),
    .saturated   (saturated)
  );

endmodule

FILE: test/cascaded_biquad_svf_equalizer_core_tb.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_svf_equalizer_core_tb
// Drives sample words and coefficient, mode and band-count writes into the
// equalizer core and checks every filtered sample against a fixed-point
// model of the biquad and state-variable cascade kept in the bench.
// ----------------------------------------------------------------------------
module cascaded_biquad_svf_equalizer_core_tb;
  import cbeq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 16;
  localparam int BANDS = 16;
  localparam int FRAC = 28;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    req_t        req;
    logic [3:0]  ch;
    logic [3:0]  bnd;
    logic [3:0]  sel;
    logic [31:0] cval;
    logic [31:0] smp;
    logic        byp;
    logic        svf;
    logic [4:0]  cnt;
  } word_t;

  typedef struct packed {
    logic [31:0] smp;
    logic [3:0]  ch;
    logic        sat;
  } eq_out_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [3:0] channel = '0, band = '0, coef_select = '0;
  logic signed [31:0] coef_value = '0, sample_in = '0;
  logic bypass_flag = 0, svf_flag = 0;
  logic [4:0] band_count = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] sample_out;
  logic [3:0] channel_out;
  logic saturated;

  cascaded_biquad_svf_equalizer_core dut (.*);

  always #1 clk = ~clk;

  word_t   pending_words[$];
  eq_out_t expected_samples[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  int idle_cycles = 0;

  logic signed [31:0] coefs[CHANNELS][BANDS][NCOEF];
  logic signed [31:0] sec_state[CHANNELS][BANDS][2];
  logic mode_byp[CHANNELS][BANDS];
  logic mode_svf[CHANNELS][BANDS];
  logic [4:0] band_counts[CHANNELS];

  function automatic longint scale_mul(longint c, longint v);
    return (c * v) >>> FRAC;
  endfunction

  function automatic longint clip32(longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic equalize(input word_t w);
    longint x, s0, s1, v1, v2, v3, y;
    bit sat, quiet;
    eq_out_t r;
    x = longint'(signed'(w.smp));
    sat = 0;
    quiet = 0;
    if (w.req == REQ_SAMPLE) begin
      for (int b = 0; b < band_counts[w.ch]; b++) begin
        if (mode_byp[w.ch][b]) continue;
        s0 = sec_state[w.ch][b][0];
        s1 = sec_state[w.ch][b][1];
        if (mode_svf[w.ch][b]) begin
          v3 = x - s1;
          v1 = clip32(scale_mul(coefs[w.ch][b][5], s0) + scale_mul(coefs[w.ch][b][6], v3),
                      quiet);
          v2 = clip32(s1 + scale_mul(coefs[w.ch][b][6], s0)
                      + scale_mul(coefs[w.ch][b][7], v3), quiet);
          sec_state[w.ch][b][0] = 32'(clip32(2 * v1 - s0, quiet));
          sec_state[w.ch][b][1] = 32'(clip32(2 * v2 - s1, quiet));
          y = clip32(scale_mul(coefs[w.ch][b][8], x) + scale_mul(coefs[w.ch][b][9], v1)
                     + scale_mul(coefs[w.ch][b][10], v2), sat);
        end else begin
          y = clip32(scale_mul(coefs[w.ch][b][0], x) + s0, sat);
          sec_state[w.ch][b][0] = 32'(clip32(scale_mul(coefs[w.ch][b][1], x)
                                  - scale_mul(coefs[w.ch][b][3], y) + s1, quiet));
          sec_state[w.ch][b][1] = 32'(clip32(scale_mul(coefs[w.ch][b][2], x)
                                  - scale_mul(coefs[w.ch][b][4], y), quiet));
        end
        x = y;
      end
      r.smp = 32'(x);
      r.ch = w.ch;
      r.sat = sat;
      expected_samples.push_back(r);
    end else if (w.req == REQ_COEF) begin
      if (w.sel < NCOEF) coefs[w.ch][w.bnd][w.sel] = w.cval;
    end else if (w.req == REQ_MODE) begin
      if (mode_svf[w.ch][w.bnd] != w.svf) begin
        sec_state[w.ch][w.bnd][0] = 0;
        sec_state[w.ch][w.bnd][1] = 0;
      end
      mode_byp[w.ch][w.bnd] = w.byp;
      mode_svf[w.ch][w.bnd] = w.svf;
    end else begin
      band_counts[w.ch] = (w.cnt > BANDS) ? 5'(BANDS) : w.cnt;
    end
  endtask

  function automatic word_t blank_word();
    word_t w;
    w = '0;
    w.cval = $urandom;
    w.smp = $urandom;
    w.bnd = 4'($urandom);
    w.sel = 4'($urandom);
    w.byp = 1'($urandom);
    w.svf = 1'($urandom);
    w.cnt = 5'($urandom);
    return w;
  endfunction

  task automatic add_sample(input logic [3:0] ch, input logic [31:0] x);
    word_t w;
    w = blank_word();
    w.req = REQ_SAMPLE;
    w.ch = ch;
    w.smp = x;
    pending_words.push_back(w);
  endtask

  task automatic add_coef(input logic [3:0] ch, input logic [3:0] b, input logic [3:0] s,
                          input logic [31:0] v);
    word_t w;
    w = blank_word();
    w.req = REQ_COEF;
    w.ch = ch;
    w.bnd = b;
    w.sel = s;
    w.cval = v;
    pending_words.push_back(w);
  endtask

  task automatic add_mode(input logic [3:0] ch, input logic [3:0] b, input logic byp,
                          input logic svf);
    word_t w;
    w = blank_word();
    w.req = REQ_MODE;
    w.ch = ch;
    w.bnd = b;
    w.byp = byp;
    w.svf = svf;
    pending_words.push_back(w);
  endtask

  task automatic add_count(input logic [3:0] ch, input logic [4:0] n);
    word_t w;
    w = blank_word();
    w.req = REQ_COUNT;
    w.ch = ch;
    w.cnt = n;
    pending_words.push_back(w);
  endtask

  // small coefficient, mostly stable: magnitude at most 0.25
  function automatic logic [31:0] mild_coef();
    return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  function automatic logic [31:0] any_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return mild_coef();
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        equalize(pending_words.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && ($urandom_range(0, 99) >= send_idle)) begin
          in_valid <= 1;
          req_type <= pending_words[0].req;
          channel <= pending_words[0].ch;
          band <= pending_words[0].bnd;
          coef_select <= pending_words[0].sel;
          coef_value <= pending_words[0].cval;
          sample_in <= pending_words[0].smp;
          bypass_flag <= pending_words[0].byp;
          svf_flag <= pending_words[0].svf;
          band_count <= pending_words[0].cnt;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    eq_out_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected word ch %0d sample %h", $time, channel_out, sample_out);
          errors++;
        end else begin
          e = expected_samples.pop_front();
          if (sample_out !== e.smp) begin
            $display("%0t: sample_out expected %h actual %h", $time, e.smp, sample_out);
            errors++;
          end
          if (channel_out !== e.ch) begin
            $display("%0t: channel_out expected %0d actual %0d", $time, e.ch, channel_out);
            errors++;
          end
          if (saturated !== e.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** cascaded_biquad_svf_equalizer_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    int ch, b;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(0, 3);
      b = $urandom_range(0, 15);
      case ($urandom_range(0, 19))
        0, 1, 2: add_coef(4'(ch), 4'(b), 4'($urandom_range(0, 15)), any_coef());
        3: add_mode(4'(ch), 4'(b), 1'($urandom), 1'($urandom));
        4: add_count(4'(ch), 5'($urandom_range(0, 31)));
        default: begin
          ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : ch;
          add_sample(4'(ch), ($urandom_range(0, 7) == 0) ? $urandom
                     : 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000));
        end
      endcase
    end
  endtask

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      band_counts[c] = 10;
      for (int b = 0; b < BANDS; b++) begin
        mode_byp[c][b] = 1;
        mode_svf[c][b] = 0;
        sec_state[c][b][0] = 0;
        sec_state[c][b][1] = 0;
        for (int k = 0; k < NCOEF; k++) coefs[c][b][k] = (k == 0) ? 32'sh1000_0000 : 0;
      end
    end
    repeat (7) @(posedge clk);
    rst <= 0;

    add_sample(0, 32'h7fff_ffff);
    add_sample(15, 32'h8000_0000);
    add_coef(0, 0, 0, 32'h7fff_ffff);
    add_mode(0, 0, 0, 0);
    add_sample(0, 32'h7fff_ffff);
    add_sample(0, 32'h8000_0000);
    add_coef(0, 1, 5, 32'h0800_0000);
    add_coef(0, 1, 6, 32'h0400_0000);
    add_coef(0, 1, 7, 32'h0200_0000);
    add_coef(0, 1, 8, 32'h1000_0000);
    add_coef(0, 1, 9, 32'h8000_0000);
    add_coef(0, 1, 10, 32'h0100_0000);
    add_coef(0, 1, 11, 32'h1234_5678);
    add_mode(0, 1, 0, 1);
    add_sample(0, 32'h0100_0000);
    add_mode(0, 1, 1, 1);
    add_sample(0, 32'h0100_0000);
    add_mode(0, 1, 0, 0);
    add_count(0, 31);
    add_count(1, 0);
    add_sample(1, 32'h1234_5678);
    add_count(2, 16);
    add_sample(0, 32'hffff_ffff);
    drain();

    send_idle = 49;
    random_phase(160);
    drain();
    send_idle = 0;
    recv_stall = 49;
    random_phase(160);
    drain();
    send_idle = 18;
    recv_stall = 18;
    hold_off = 3000;
    random_phase(160);
    drain();
    send_idle = 0;
    recv_stall = 0;
    random_phase(160);
    drain();

    if (errors == 0) begin
      $display("** cascaded_biquad_svf_equalizer_core: PASSED **");
    end else begin
      $display("** cascaded_biquad_svf_equalizer_core: FAILED **");
    end
    $finish;
  end
endmodule
